// ===== sv/median_filter_3x3_with_borders_macros.svh =====
// Assertion macros for the median filter block.
`ifndef MEDIAN_FILTER_3X3_WITH_BORDERS_MACROS_SVH
`define MEDIAN_FILTER_3X3_WITH_BORDERS_MACROS_SVH
// Property a must imply b in the next cycle.
`define MF_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
// Property a must imply b in the same cycle.
`define MF_ASSERT_NOW(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`endif

// ===== sv/mf3_pkg.sv =====
// Package: shared types, constants and filter functions for the median filter.
`timescale 1ns / 1ps
`default_nettype none
package mf3_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;
    localparam int IDX_W = 1;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 1'b1;
    localparam int QDEPTH = 4;

    typedef logic [PIX_W-1:0] pix_t;

    // One classified job: window snapshot plus which outputs it makes.
    typedef struct packed {
        pix_t [8:0]       win;
        logic [3:0]       emit;     // a: (y-1,x-1) b: (y-1,x) c: (y,x-1) d: (y,x)
        logic             top_edge; // y-1 == 0
        logic             left_edge;// x-1 == 0
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             final_px;
    } job_t;

    typedef struct packed {
        pix_t             pixel_out;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             last_of_run;
        logic             frame_done;
    } res_t;

    function automatic pix_t mx(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction
    function automatic pix_t mn(input pix_t a, input pix_t b);
        return (a > b) ? b : a;
    endfunction
    function automatic pix_t avg2(input pix_t a, input pix_t b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

    // Median of three.
    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return mx(mn(a, b), mn(mx(a, b), c));
    endfunction

    // Median of nine via column sort network.
    function automatic pix_t med9(input pix_t [8:0] v);
        pix_t lo0, lo1, lo2, md0, md1, md2, hi0, hi1, hi2;
        pix_t a, b, c;
        logic [3:0] k;
        pix_t [2:0] s;
        for (k = 0; k < 3; k++)
        begin
            a = v[k]; b = v[k+3]; c = v[k+6];
            s[0] = mn(mn(a, b), c);
            s[2] = mx(mx(a, b), c);
            s[1] = med3(a, b, c);
            if (k == 0) begin lo0 = s[0]; md0 = s[1]; hi0 = s[2]; end
            else if (k == 1) begin lo1 = s[0]; md1 = s[1]; hi1 = s[2]; end
            else begin lo2 = s[0]; md2 = s[1]; hi2 = s[2]; end
        end
        return med3(mx(mx(lo0, lo1), lo2), med3(md0, md1, md2), mn(mn(hi0, hi1), hi2));
    endfunction

    // Mean of middle two of four.
    function automatic pix_t mid4(input pix_t a, input pix_t b, input pix_t c,
                                  input pix_t d);
        return avg2(mx(mn(a, b), mn(c, d)), mn(mx(a, b), mx(c, d)));
    endfunction

    // Mean of middle two (3rd and 4th smallest) of six.
    function automatic pix_t mid6(input pix_t [5:0] v);
        pix_t [5:0] s;
        pix_t t;
        logic [2:0] i, j;
        s = v;
        for (i = 0; i < 6; i++)
        begin
            for (j = 0; j < 5; j++)
            begin
                if (j[0] == i[0] && s[j] > s[j+1])
                begin
                    t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                end
            end
        end
        return avg2(s[2], s[3]);
    endfunction
endpackage
`default_nettype wire

// ===== sv/mf3_if.sv =====
// Interfaces: pixel stream, result stream and configuration channel.
`timescale 1ns / 1ps
`default_nettype none
interface mf3_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mf3_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       last_of_run;
    logic       frame_done;
    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input last_of_run, input frame_done, output ready);
endinterface

interface mf3_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [10:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/mf3_front.sv =====
// Front end: line buffers, window, position tracking and job classification.
`timescale 1ns / 1ps
`default_nettype none
module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pix_t              pix,
    input  wire logic              cfg_we,
    input  wire logic              cfg_idx,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output job_t                   job
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int DW = (AW > HW ? AW : HW) + 2;

    pix_t la_mem [MAX_WIDTH];
    pix_t lb_mem [MAX_WIDTH];

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [AW-1:0]    col_reg, col_next;
    logic [HW-1:0]    row_reg, row_next;
    logic [DW-1:0]    w_eff, h_eff;
    pix_t [8:0]       win_reg, win_next;
    // stage 1: pixel captured, memory read in flight
    logic             s1_vld_reg;
    pix_t             s1_pix_reg;
    logic [AW-1:0]    s1_col_reg;
    logic [HW-1:0]    s1_row_reg;
    pix_t             rd_a_reg, rd_b_reg;
    logic             jv_reg;
    job_t             job_reg, job_next;
    logic             adv, s1_go;

    always_comb
    begin
        if (width_reg < CFG_W'(2))
            w_eff = DW'(2);
        else if ({{(DW > CFG_W ? DW - CFG_W : 0){1'b0}}, width_reg} > DW'(MAX_WIDTH))
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = DW'(width_reg);
        if (height_reg < CFG_W'(2))
            h_eff = DW'(2);
        else if ({{(DW > CFG_W ? DW - CFG_W : 0){1'b0}}, height_reg} > DW'(MAX_HEIGHT))
            h_eff = DW'(MAX_HEIGHT);
        else
            h_eff = DW'(height_reg);
    end

    // Output register advances when empty or taken.
    assign s1_go    = !jv_reg || job_ready;
    assign in_ready = s1_go;
    assign adv      = in_valid && in_ready;

    always_comb
    begin
        if (DW'(col_reg) + DW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = (DW'(row_reg) + DW'(1) >= h_eff) ? '0 : row_reg + HW'(1);
        end
        else
        begin
            col_next = col_reg + AW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
            s1_vld_reg <= 1'b0;
            jv_reg     <= 1'b0;
            win_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (adv)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_go)
            begin
                s1_vld_reg <= adv;
                jv_reg     <= s1_vld_reg;
                if (s1_vld_reg)
                    win_reg <= win_next;
            end
        end
    end

    // Same-address read/write: read returns old data.
    // The older line takes the registered read of the newer one when the
    // pixel leaves stage 1, before that column is read again.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg <= pix;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
            rd_a_reg   <= la_mem[col_reg];
            rd_b_reg   <= lb_mem[col_reg];
            la_mem[col_reg] <= pix;
        end
        if (s1_go && s1_vld_reg)
        begin
            job_reg <= job_next;
            lb_mem[s1_col_reg] <= rd_a_reg;
        end
    end

    always_comb
    begin
        win_next = win_reg;
        win_next[0] = win_reg[1]; win_next[1] = win_reg[2];
        win_next[3] = win_reg[4]; win_next[4] = win_reg[5];
        win_next[6] = win_reg[7]; win_next[7] = win_reg[8];
        win_next[2] = rd_b_reg;
        win_next[5] = rd_a_reg;
        win_next[8] = s1_pix_reg;
        job_next.win = win_next;
        job_next.top_edge  = (s1_row_reg == HW'(1));
        job_next.left_edge = (s1_col_reg == AW'(1));
        job_next.row = POS_W'(s1_row_reg);
        job_next.col = POS_W'(s1_col_reg);
        job_next.emit[0] = (s1_row_reg != '0) && (s1_col_reg != '0);
        job_next.emit[1] = (s1_row_reg != '0) && (DW'(s1_col_reg) == w_eff - DW'(1));
        job_next.emit[2] = job_next.emit[0] && (DW'(s1_row_reg) == h_eff - DW'(1));
        job_next.emit[3] = job_next.emit[1] && (DW'(s1_row_reg) == h_eff - DW'(1));
        job_next.final_px = (DW'(s1_row_reg) == h_eff - DW'(1))
                         && (DW'(s1_col_reg) == w_eff - DW'(1));
    end

    assign job_valid = jv_reg && (job_reg.emit != '0);
    assign job       = job_reg;
endmodule
`default_nettype wire

// ===== sv/mf3_queue.sv =====
// Short FIFO of classified jobs between front and back.
`timescale 1ns / 1ps
`default_nettype none
module mf3_queue
    import mf3_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire job_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);
    localparam int PW = $clog2(QDEPTH);
    job_t          mem_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + PW'(1);
            if (rd) rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// ===== sv/mf3_back.sv =====
// Back end: computes filter results, issues up to four per job.
`timescale 1ns / 1ps
`default_nettype none
module mf3_back
    import mf3_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);
    // Stage A: compute all four candidate values.
    logic       a_vld_reg;
    pix_t [3:0] a_val_reg;
    job_t       a_job_reg;
    logic [3:0] a_left_reg; // emits still pending
    // Output register
    logic       o_vld_reg;
    res_t       o_reg;
    pix_t [3:0] val;
    logic [3:0] sel, rest;
    logic       o_free, a_done, take;
    logic [1:0] k;
    pix_t [8:0] w;

    always_comb
    begin
        w = job.win;
        // (y-1,x-1): full rows unless top edge, full cols unless left edge
        case ({job.top_edge, job.left_edge})
            2'b00:   val[0] = med9(w);
            2'b10:   val[0] = mid6({w[8], w[7], w[6], w[5], w[4], w[3]});
            2'b01:   val[0] = mid6({w[8], w[7], w[5], w[4], w[2], w[1]});
            default: val[0] = mid4(w[4], w[5], w[7], w[8]);
        endcase
        if (job.top_edge)
            val[1] = mid4(w[4], w[5], w[7], w[8]);
        else
            val[1] = mid6({w[8], w[7], w[5], w[4], w[2], w[1]});
        if (job.left_edge)
            val[2] = mid4(w[4], w[5], w[7], w[8]);
        else
            val[2] = mid6({w[8], w[7], w[6], w[5], w[4], w[3]});
        val[3] = mid4(w[4], w[5], w[7], w[8]);
    end

    assign o_free = !o_vld_reg || res_ready;

    // Lowest pending emit goes next.
    always_comb
    begin
        sel = a_left_reg & ~(a_left_reg - 4'd1);
        rest = a_left_reg & ~sel;
        k = sel[1] ? 2'd1 : sel[2] ? 2'd2 : sel[3] ? 2'd3 : 2'd0;
    end

    assign take      = a_vld_reg && o_free;
    assign a_done    = take && (rest == '0);
    assign job_ready = !a_vld_reg || a_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            a_left_reg <= '0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            if (job_valid && job_ready)
            begin
                a_vld_reg  <= 1'b1;
                a_left_reg <= job.emit;
            end
            else if (a_done)
                a_vld_reg <= 1'b0;
            else if (take)
                a_left_reg <= rest;
            if (take)
                o_vld_reg <= 1'b1;
            else if (res_ready)
                o_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            a_val_reg <= val;
            a_job_reg <= job;
        end
        if (take)
        begin
            o_reg.pixel_out   <= a_val_reg[k];
            o_reg.out_row     <= k[1] ? a_job_reg.row : a_job_reg.row - POS_W'(1);
            o_reg.out_col     <= k[0] ? a_job_reg.col : a_job_reg.col - POS_W'(1);
            o_reg.last_of_run <= (rest == '0);
            o_reg.frame_done  <= a_job_reg.final_px;
        end
    end

    assign res_valid = o_vld_reg;
    assign res       = o_reg;
endmodule
`default_nettype wire

// ===== sv/median_filter_3x3_with_borders.sv =====
// Top level of the streaming 3x3 median filter with border handling.
//  channel | role   | carries
//  pix     | sink   | pixel_in
//  res     | source | pixel_out, out_row, out_col, last_of_run, frame_done
//  cfg     | sink   | index (0 width, 1 height), data
// Up to one pixel accepted per cycle; results flow through a 4-deep job queue.
// Path: a pixel passes the line buffer read, window, queue, sort and output register
// in order; the back end issues one result per cycle while res is ready.
// The extra result of a right-column pixel is absorbed by the queue; on the last row
// most pixels make two results, so input there is held back by queue back-pressure.
// Reset: position (0,0), width 640, height 480; line buffers are not cleared.
// Any stall on res backs up through the queue into pix ready.
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_3x3_with_borders_macros.svh"
module median_filter_3x3_with_borders
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mf3_pix_if.sink    pix,
    mf3_res_if.source  res,
    mf3_cfg_if.sink    cfg
);
    logic f_valid, f_ready, q_valid, q_ready, r_valid;
    job_t f_job, q_job;
    res_t r_data;

    // Config is always taken; the user must keep the block idle when it is written, as the block does not enforce it.
    assign cfg.ready = 1'b1;

    mf3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pix.valid), .in_ready(pix.ready), .pix(pix.pixel_in),
        .cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    mf3_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    mf3_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .res_valid(r_valid), .res_ready(res.ready), .res(r_data)
    );

    assign res.valid       = r_valid;
    assign res.pixel_out   = r_data.pixel_out;
    assign res.out_row     = r_data.out_row;
    assign res.out_col     = r_data.out_col;
    assign res.last_of_run = r_data.last_of_run;
    assign res.frame_done  = r_data.frame_done;

    `MF_ASSERT_NEXT(a_res_hold, clk, rst_n, res.valid && !res.ready, res.valid)
    `MF_ASSERT_NOW(a_frame_last, clk, rst_n, res.valid && res.frame_done && res.last_of_run,
        res.out_row != 10'd0)
    `MF_ASSERT_NOW(a_q_ready, clk, rst_n, !f_ready, q_valid)
endmodule
`default_nettype wire
